[src/sat_pkg.sv]
// ----------------------------------------------------------------------------
// sat_pkg - section address translator shared definitions
// Command codes, register indexes, table entry layout and sequencer states.
// ----------------------------------------------------------------------------
package sat_pkg;

  // Transaction commands
  typedef enum logic [1:0] {
    CMD_LOAD = 2'd0,
    CMD_V2F  = 2'd1,
    CMD_F2V  = 2'd2,
    CMD_NONE = 2'd3
  } sat_cmd_t;

  // Register indexes (byte address / 4)
  localparam logic REG_HEADER_SIZE   = 1'b0;
  localparam logic REG_SECTION_COUNT = 1'b1;

  localparam int ADDR_W  = 32;
  localparam int COUNT_W = 5;
  localparam int IDX_W   = 4;
  localparam int PADDR_W = 3;
  localparam int PAGE_W  = 12;  // 4 KiB page

  // One section table entry
  typedef struct packed {
    logic [ADDR_W-1:0] virt_size;
    logic [ADDR_W-1:0] virt_base;
    logic [ADDR_W-1:0] raw_size;
    logic [ADDR_W-1:0] raw_base;
  } sec_entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } sat_state_t;

  // Round a size up to the next page boundary, wrapping at 2^32
  function automatic logic [ADDR_W-1:0] page_round_up(input logic [ADDR_W-1:0] v);
    logic [ADDR_W-PAGE_W-1:0] pg;
    pg = v[ADDR_W-1:PAGE_W] + (ADDR_W-PAGE_W)'(|v[PAGE_W-1:0]);
    return {pg, {PAGE_W{1'b0}}};
  endfunction

endpackage

[src/sat_in_if.sv]
// ----------------------------------------------------------------------------
// sat_in_if - request channel
// Valid/ready channel carrying one load or translate transaction.
// ----------------------------------------------------------------------------
interface sat_in_if
  import sat_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [1:0]        cmd;
  logic [IDX_W-1:0]  entry_index;
  logic [ADDR_W-1:0] virt_size;
  logic [ADDR_W-1:0] virt_base;
  logic [ADDR_W-1:0] raw_size;
  logic [ADDR_W-1:0] raw_base;
  logic [ADDR_W-1:0] query_addr;

  modport source (output valid, cmd, entry_index, virt_size, virt_base, raw_size,
                  raw_base, query_addr, input ready);
  modport sink   (input valid, cmd, entry_index, virt_size, virt_base, raw_size,
                  raw_base, query_addr, output ready);
endinterface

[src/sat_out_if.sv]
// ----------------------------------------------------------------------------
// sat_out_if - result channel
// Valid/ready channel carrying one translation result.
// ----------------------------------------------------------------------------
interface sat_out_if
  import sat_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] translated_addr;
  logic              matched;

  modport source (output valid, translated_addr, matched, input ready);
  modport sink   (input valid, translated_addr, matched, output ready);
endinterface

[src/section_address_translator.sv]
// ----------------------------------------------------------------------------
// section_address_translator - section table and address translation
//
//   Channel  | Port group        | Direction | Content
//   ---------+-------------------+-----------+------------------------------------
//   request  | in_ch             | in        | load entry or translate query
//   result   | out_ch            | out       | translated_addr, matched
//   config   | psel..prdata      | in/out    | header_size @0x0, section_count @0x4
//
// A load is written into the table on acceptance and the block stays ready. A
// table scan reads one table entry per cycle from the section RAM into a
// three-stage compare pipeline, then drains, and offers its result from DONE;
// header pass-through and an empty table go straight to DONE. In each case the
// block is ready again once the result register has been loaded.
// The result register holds a finished transaction until out_ch.ready; a
// further translate waits in DONE while that register is full.
// Reset (rst_n, synchronous) clears control and registers and holds in_ch.ready
// low; the table is undefined until loaded.
// ----------------------------------------------------------------------------
module section_address_translator
  import sat_pkg::*;
#(
  parameter int MAX_SECTIONS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  sat_in_if.sink             in_ch,
  sat_out_if.source          out_ch,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int AW = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;

  sat_state_t state_r, state_nxt;

  logic [ADDR_W-1:0]  hdr_r;
  logic [COUNT_W-1:0] cnt_r;
  logic               dir_v2f_r;
  logic [ADDR_W-1:0]  query_r;
  logic [AW-1:0]      rd_idx_r;
  logic               v1_r, v2_r, v3_r;
  logic [ADDR_W-1:0]  ext2_r, lo2_r, oth2_r, diff2_r;
  logic [ADDR_W-1:0]  hi3_r, res3_r;
  logic               ge3_r;
  logic [ADDR_W-1:0]  res_r;
  logic               hit_r;
  logic               out_valid_r;
  logic [ADDR_W-1:0]  out_addr_r;
  logic               out_hit_r;

  logic               accept, is_xlate, pass, ld_ok, last_issue;
  logic               issue, out_load, cfg_wr;
  logic [COUNT_W-1:0] cnt_wval;
  sec_entry_t         ram_wdata, ram_rdata;
  logic [ADDR_W-1:0]  s1_lo, s1_ext, s1_oth;

  // --------------------------------------------------------------------------
  // Configuration port
  // --------------------------------------------------------------------------
  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign cnt_wval = (7'(pwdata[COUNT_W-1:0]) > 7'(MAX_SECTIONS)) ?
                    COUNT_W'(MAX_SECTIONS) : pwdata[COUNT_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_r <= '0;
      cnt_r <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_HEADER_SIZE:   hdr_r <= pwdata;
        REG_SECTION_COUNT: cnt_r <= cnt_wval;
        default:           ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_HEADER_SIZE:   prdata = hdr_r;
      REG_SECTION_COUNT: prdata = 32'(cnt_r);
      default:           prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Request decode
  // --------------------------------------------------------------------------
  assign accept   = in_ch.valid && in_ch.ready;
  assign is_xlate = (in_ch.cmd == CMD_V2F) || (in_ch.cmd == CMD_F2V);
  assign pass     = (in_ch.cmd == CMD_V2F) && (in_ch.query_addr <= hdr_r);
  assign ld_ok    = accept && (in_ch.cmd == CMD_LOAD) &&
                    (7'(in_ch.entry_index) < 7'(MAX_SECTIONS));
  assign last_issue = (8'(rd_idx_r) + 8'd1) == 8'(cnt_r);

  // --------------------------------------------------------------------------
  // Section table
  // --------------------------------------------------------------------------
  assign ram_wdata = '{virt_size: in_ch.virt_size, virt_base: in_ch.virt_base,
                       raw_size:  in_ch.raw_size,  raw_base:  in_ch.raw_base};

  sat_ram #(
    .WIDTH ($bits(sec_entry_t)),
    .DEPTH (MAX_SECTIONS),
    .AW    (AW)
  ) u_table (
    .clk   (clk),
    .we    (ld_ok),
    .waddr (AW'(in_ch.entry_index)),
    .wdata (ram_wdata),
    .re    (issue),
    .raddr (rd_idx_r),
    .rdata (ram_rdata)
  );

  // --------------------------------------------------------------------------
  // Sequencer: next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && is_xlate) begin
          state_nxt = (pass || (cnt_r == '0)) ? ST_DONE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (last_issue) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!v1_r && !v2_r && !v3_r) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_load) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer: outputs
  always_comb begin
    in_ch.ready = (state_r == ST_IDLE) && rst_n;
    issue       = (state_r == ST_SCAN);
    out_load    = (state_r == ST_DONE) && (!out_valid_r || out_ch.ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      v3_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      v1_r    <= issue;
      v2_r    <= v1_r;
      v3_r    <= v2_r;
    end
  end

  // Read pointer and query capture
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE) begin
      rd_idx_r <= '0;
      if (accept) begin
        query_r   <= in_ch.query_addr;
        dir_v2f_r <= (in_ch.cmd == CMD_V2F);
      end
    end else if (issue) begin
      rd_idx_r <= rd_idx_r + AW'(1);
    end
  end

  // --------------------------------------------------------------------------
  // Compare pipeline: extent and offset, then bounds and result, then update
  // --------------------------------------------------------------------------
  assign s1_lo  = dir_v2f_r ? ram_rdata.virt_base : ram_rdata.raw_base;
  assign s1_ext = dir_v2f_r ? page_round_up(ram_rdata.virt_size) : ram_rdata.raw_size;
  assign s1_oth = dir_v2f_r ? ram_rdata.raw_base : ram_rdata.virt_base;

  always_ff @(posedge clk) begin
    ext2_r  <= s1_ext;
    lo2_r   <= s1_lo;
    oth2_r  <= s1_oth;
    diff2_r <= query_r - s1_lo;
    hi3_r   <= ext2_r + lo2_r;
    ge3_r   <= query_r >= lo2_r;
    res3_r  <= diff2_r + oth2_r;
  end

  // Running result; later matches overwrite earlier ones
  always_ff @(posedge clk) begin
    if (accept && is_xlate) begin
      res_r <= pass ? in_ch.query_addr : '0;
      hit_r <= pass;
    end else if (v3_r && ge3_r && (query_r < hi3_r)) begin
      res_r <= res3_r;
      hit_r <= 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_addr_r <= res_r;
      out_hit_r  <= hit_r;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.translated_addr = out_addr_r;
  assign out_ch.matched         = out_hit_r;

endmodule

[src/sat_ram.sv]
// ----------------------------------------------------------------------------
// sat_ram - generic single-port-write, registered-read RAM
// One write and one read per cycle; read data appears the cycle after re.
// ----------------------------------------------------------------------------
module sat_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[src/sat_checker.sv]
// ----------------------------------------------------------------------------
// sat_checker - port-level checks for the section address translator
// Watches the request and result channels and flags sequencing slips.
// ----------------------------------------------------------------------------
module sat_checker
  import sat_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic [1:0]        in_cmd,
  input logic              out_valid,
  input logic              out_ready,
  input logic [ADDR_W-1:0] out_translated_addr,
  input logic              out_matched
);

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_translated_addr) && $stable(out_matched))
    else $error("result payload changed while stalled");

  // A miss always reports address zero
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_matched |-> out_translated_addr == '0)
    else $error("unmatched result carries nonzero address");

  // A translate transaction occupies the sequencer for the next cycle
  a_busy_after_xlate: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_cmd == CMD_V2F || in_cmd == CMD_F2V) |=> !in_ready)
    else $error("request accepted during translation");

endmodule

bind section_address_translator sat_checker u_sat_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_valid            (in_ch.valid),
  .in_ready            (in_ch.ready),
  .in_cmd              (in_ch.cmd),
  .out_valid           (out_ch.valid),
  .out_ready           (out_ch.ready),
  .out_translated_addr (out_ch.translated_addr),
  .out_matched         (out_ch.matched)
);

[tb/xlat_checker.sv]
// ----------------------------------------------------------------------------
// xlat_checker - result checker for the section address translator
// Watches the request, result and register ports, keeps its own copy of the
// section table and registers, predicts every translation and compares each
// result transaction with the oldest prediction.
// ----------------------------------------------------------------------------
module xlat_checker
  import sat_pkg::*;
#(
  parameter int SECTIONS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  sat_in_if                  req,
  sat_out_if                 rsp,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  input  logic               pready,
  output int                 fail_count,
  output int                 pending
);

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic              hit;
  } xlat_result_t;

  // Shadow registers and section table
  logic [ADDR_W-1:0] hdr_limit;
  int                scan_len;
  logic [ADDR_W-1:0] sz_virt [SECTIONS];
  logic [ADDR_W-1:0] at_virt [SECTIONS];
  logic [ADDR_W-1:0] sz_raw  [SECTIONS];
  logic [ADDR_W-1:0] at_raw  [SECTIONS];

  xlat_result_t xlat_due[$];

  initial begin
    fail_count = 0;
    pending    = 0;
    hdr_limit  = '0;
    scan_len   = 0;
  end

  // Translation of one query against the current table, last hit wins
  function automatic xlat_result_t predict_xlat(input sat_cmd_t op, input logic [31:0] q);
    xlat_result_t r;
    logic [31:0]  lo;
    logic [31:0]  hi;
    logic [31:0]  other;
    r = '0;
    if (op == CMD_V2F && q <= hdr_limit) begin
      r.addr = q;
      r.hit  = 1'b1;
      return r;
    end
    for (int i = 0; i < scan_len; i++) begin
      if (op == CMD_V2F) begin
        lo    = at_virt[i];
        hi    = lo + ((sz_virt[i] + 32'hFFF) & ~32'hFFF);  // page-rounded extent, wraps
        other = at_raw[i];
      end else begin
        lo    = at_raw[i];
        hi    = lo + sz_raw[i];
        other = at_virt[i];
      end
      if (q >= lo && q < hi) begin
        r.addr = q - lo + other;
        r.hit  = 1'b1;
      end
    end
    return r;
  endfunction

  // Register writes, request tracking and result comparison
  always @(posedge clk) begin
    xlat_result_t want;
    logic [4:0]   cnt_field;
    if (!rst_n) begin
      hdr_limit = '0;
      scan_len  = 0;
      xlat_due.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_HEADER_SIZE) begin
          hdr_limit = pwdata;
        end else begin
          cnt_field = pwdata[4:0];
          scan_len  = (cnt_field > SECTIONS) ? SECTIONS : int'(cnt_field);
        end
      end

      if (rsp.valid && rsp.ready) begin
        if (xlat_due.size() == 0) begin
          $error("result with nothing outstanding: translated_addr %h matched %b",
                 rsp.translated_addr, rsp.matched);
          fail_count++;
        end else begin
          want = xlat_due.pop_front();
          if (rsp.translated_addr !== want.addr) begin
            $error("translated_addr: expected %h, got %h", want.addr, rsp.translated_addr);
            fail_count++;
          end
          if (rsp.matched !== want.hit) begin
            $error("matched: expected %b, got %b", want.hit, rsp.matched);
            fail_count++;
          end
        end
      end

      if (req.valid && req.ready) begin
        case (sat_cmd_t'(req.cmd))
          CMD_LOAD: begin
            if (req.entry_index < SECTIONS) begin
              sz_virt[req.entry_index] = req.virt_size;
              at_virt[req.entry_index] = req.virt_base;
              sz_raw[req.entry_index]  = req.raw_size;
              at_raw[req.entry_index]  = req.raw_base;
            end
          end
          CMD_V2F, CMD_F2V: begin
            xlat_due.push_back(predict_xlat(sat_cmd_t'(req.cmd), req.query_addr));
          end
          default: ;  // unused command, no result
        endcase
      end
    end
    pending = xlat_due.size();
  end

endmodule

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb - testbench top for section_address_translator
// Drives load and translate transactions in bursts with random gaps, stalls
// the result channel on its own pattern (with one long hold-off), steps the
// registers through several settings between phases, and reports the verdict
// from the checker's failure count.
// ----------------------------------------------------------------------------
module tb;
  import sat_pkg::*;

  localparam int SECTIONS = 16;
  localparam logic [PADDR_W-1:0] HDR_ADDR = {REG_HEADER_SIZE, 2'b00};
  localparam logic [PADDR_W-1:0] CNT_ADDR = {REG_SECTION_COUNT, 2'b00};
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 30;  // margin for the longest translate to finish

  logic clk = 1'b0;
  logic rst_n;

  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  int fail_count;
  int pending;

  sat_in_if  in_ch ();
  sat_out_if out_ch ();

  section_address_translator #(
    .MAX_SECTIONS(SECTIONS)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  xlat_checker #(
    .SECTIONS(SECTIONS)
  ) u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (in_ch),
    .rsp       (out_ch),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .pready    (pready),
    .fail_count(fail_count),
    .pending   (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Stimulus-side view of the table, used only to aim queries at sections
  logic [31:0] tbl_vs [SECTIONS];
  logic [31:0] tbl_vb [SECTIONS];
  logic [31:0] tbl_rs [SECTIONS];
  logic [31:0] tbl_rb [SECTIONS];
  logic [31:0] cur_header = '0;
  int          cur_count  = 0;
  int          burst_left;
  int          hold_ask   = 0;

  // Result channel: stall pattern changing mode now and then, plus hold-off
  initial begin
    int hold_seen;
    int hold_left;
    int mode;
    int mode_left;
    hold_seen = 0;
    hold_left = 0;
    mode      = 0;
    mode_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left == 0 && hold_ask != hold_seen) begin
        hold_seen = hold_ask;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 2);
          mode_left = $urandom_range(10, 60);
        end
        mode_left--;
        case (mode)
          0:       out_ch.ready <= 1'b1;
          1:       out_ch.ready <= 1'($urandom_range(0, 1));
          default: out_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // One request transaction; gaps between bursts are taken after acceptance
  task automatic put_item(input sat_cmd_t op, input logic [3:0] idx,
                          input logic [31:0] vs, input logic [31:0] vb,
                          input logic [31:0] rs, input logic [31:0] rb,
                          input logic [31:0] q);
    int gap;
    in_ch.valid       <= 1'b1;
    in_ch.cmd         <= op;
    in_ch.entry_index <= idx;
    in_ch.virt_size   <= vs;
    in_ch.virt_base   <= vb;
    in_ch.raw_size    <= rs;
    in_ch.raw_base    <= rb;
    in_ch.query_addr  <= q;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (op == CMD_LOAD) begin
      tbl_vs[idx] = vs;
      tbl_vb[idx] = vb;
      tbl_rs[idx] = rs;
      tbl_rb[idx] = rb;
    end
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Let outstanding translations come back and the sequencer go idle
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [PADDR_W-1:0] addr, input logic [31:0] data);
    logic [4:0] c;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == HDR_ADDR) begin
      cur_header = data;
    end else begin
      c = data[4:0];
      cur_count = (c > SECTIONS) ? SECTIONS : int'(c);
    end
    @(posedge clk);
  endtask

  // Query near a section edge, inside a section, or around the header limit
  function automatic logic [31:0] aim_query(input sat_cmd_t op);
    int          i;
    logic [31:0] lo;
    logic [31:0] span;
    logic [31:0] off;
    if (cur_count == 0 || $urandom_range(0, 9) < 3) begin
      case ($urandom_range(0, 3))
        0:       return cur_header;
        1:       return cur_header + 32'd1;
        2:       return cur_header - 32'd1;
        default: return $urandom;
      endcase
    end
    i    = $urandom_range(0, cur_count - 1);
    lo   = (op == CMD_V2F) ? tbl_vb[i] : tbl_rb[i];
    span = (op == CMD_V2F) ? ((tbl_vs[i] + 32'hFFF) & ~32'hFFF) : tbl_rs[i];
    case ($urandom_range(0, 3))
      0:       off = '0;
      1:       off = span - 32'd1;
      2:       off = span;  // just past the end
      default: off = (span == 0) ? '0 : ($urandom % span);
    endcase
    return lo + off;
  endfunction

  // Random section: mostly clustered so that sections overlap
  task automatic load_random(input logic [3:0] idx);
    if ($urandom_range(0, 7) == 0) begin
      put_item(CMD_LOAD, idx, $urandom, $urandom, $urandom, $urandom, $urandom);
    end else begin
      put_item(CMD_LOAD, idx, $urandom_range(0, 32'h6000),
               32'h0040_0000 + ($urandom_range(0, 31) << 12),
               $urandom_range(0, 32'h6000), $urandom_range(0, 32) << 9, $urandom);
    end
  endtask

  // Main stimulus
  initial begin
    int          n;
    int          roll;
    int          waited;
    sat_cmd_t    op;
    logic [31:0] hdr;
    logic [31:0] cnt;
    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.cmd         <= CMD_LOAD;
    in_ch.entry_index <= '0;
    in_ch.virt_size   <= '0;
    in_ch.virt_base   <= '0;
    in_ch.raw_size    <= '0;
    in_ch.raw_base    <= '0;
    in_ch.query_addr  <= '0;
    psel              <= 1'b0;
    penable           <= 1'b0;
    pwrite            <= 1'b0;
    paddr             <= '0;
    pwdata            <= '0;
    burst_left = $urandom_range(1, 12);
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty table: pass-through at zero, misses, unused command
    put_item(CMD_V2F, 4'h0, '0, '0, '0, '0, 32'h0);
    put_item(CMD_F2V, 4'h0, '0, '0, '0, '0, 32'hFFFF_FFFF);
    put_item(CMD_NONE, 4'hF, '1, '1, '1, '1, '1);

    // Fill every entry: zero-sized, overlapping, wrapping and all-ones sections
    put_item(CMD_LOAD, 4'd0, '0, '0, '0, '0, '0);
    put_item(CMD_LOAD, 4'd1, 32'h1800, 32'h1000, 32'h1800, 32'h400, '0);
    put_item(CMD_LOAD, 4'd2, 32'h1000, 32'h2000, 32'h1000, 32'h1000, '0);
    put_item(CMD_LOAD, 4'd3, 32'h2000, 32'hFFFF_F000, 32'h10, 32'hFFFF_FFF8, '0);
    for (int k = 4; k < 15; k++) load_random(4'(k));
    put_item(CMD_LOAD, 4'd15, '1, '1, '1, '1, '1);

    // Count write above the table depth saturates
    settle();
    cfg_write(HDR_ADDR, 32'h400);
    cfg_write(CNT_ADDR, 32'h1F);
    put_item(CMD_V2F, 4'h0, '0, '0, '0, '0, 32'h400);  // equal to header size
    put_item(CMD_V2F, 4'h0, '0, '0, '0, '0, 32'h401);
    put_item(CMD_V2F, 4'h0, '0, '0, '0, '0, 32'h1000);
    put_item(CMD_V2F, 4'h0, '0, '0, '0, '0, 32'h2FFF);  // later entry wins
    put_item(CMD_F2V, 4'h0, '0, '0, '0, '0, 32'h1800);  // later entry wins
    put_item(CMD_F2V, 4'h0, '0, '0, '0, '0, 32'hFFFF_FFF9);
    put_item(CMD_V2F, 4'h0, '0, '0, '0, '0, 32'hFFFF_FFFF);

    // Random phases, each under its own register setting
    for (int p = 0; p < 10; p++) begin
      case (p)
        0:       begin hdr = '0;                        cnt = 32'd16; end
        1:       begin hdr = 32'hFFFF_FFFF;             cnt = 32'd16; end
        2:       begin hdr = $urandom_range(0, 32'h60_0000); cnt = 32'd1; end
        3:       begin hdr = 32'h1000;                  cnt = 32'd17; end
        4:       begin hdr = '0;                        cnt = '0; end
        5:       begin hdr = $urandom;                  cnt = $urandom; end
        default: begin hdr = $urandom_range(0, 32'h50_0000); cnt = $urandom_range(2, 16); end
      endcase
      settle();
      cfg_write(HDR_ADDR, hdr);
      cfg_write(CNT_ADDR, cnt);
      if (p == 2) hold_ask <= hold_ask + 1;
      n = 0;
      while (n < 65) begin
        roll = $urandom_range(0, 99);
        if (roll < 3) begin
          put_item(CMD_NONE, 4'($urandom), $urandom, $urandom, $urandom, $urandom, $urandom);
        end else if (roll < 28) begin
          load_random(4'($urandom_range(0, SECTIONS - 1)));
          n++;
        end else begin
          op = ($urandom_range(0, 1) == 1) ? CMD_V2F : CMD_F2V;
          put_item(op, 4'($urandom), $urandom, $urandom, $urandom, $urandom, aim_query(op));
          n++;
        end
      end
    end

    // Drain and verdict
    in_ch.valid <= 1'b0;
    @(posedge clk);
    waited = 0;
    while (pending != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending != 0) $error("%0d translation results never arrived", pending);
    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #3000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
